### hdl/illinois_false_position_root_finder_defines.svh
// Assertion macros used by the checker of the root finder.
// Depends on nothing; included by the checker module.
`ifndef ILLINOIS_FALSE_POSITION_ROOT_FINDER_DEFINES_SVH
`define ILLINOIS_FALSE_POSITION_ROOT_FINDER_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define IFPR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition checked at every rising edge outside reset.
`define IFPR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

### hdl/ifpr_pkg.sv
// Package of the root finder: widths, codes, state and command types.
// Depends on nothing; imported by every module of the block.
package ifpr_pkg;

	localparam int VW      = 32;
	localparam int IW      = 10;
	localparam int TW      = 31;
	localparam int CNT_W   = $clog2(VW);

	// Result status codes.
	typedef enum logic [2:0] {
		STAT_EVAL      = 3'd0,
		STAT_CONVERGED = 3'd1,
		STAT_BAD       = 3'd2,
		STAT_LIMIT     = 3'd3,
		STAT_NO_SEARCH = 3'd4
	} status_t;

	// Which end the last value item replaced.
	localparam logic [1:0] KEEP_NONE = 2'd0;
	localparam logic [1:0] KEEP_LOW  = 2'd1;
	localparam logic [1:0] KEEP_HIGH = 2'd2;

	// Kind of report formed after a request.
	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_BAD    = 2'd1,
		MODE_IDLE   = 2'd2
	} rep_mode_t;

	// Register indexes.
	localparam logic REG_MAX_ITER  = 1'b0;
	localparam logic REG_TOLERANCE = 1'b1;

	// Controller states.
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SETUP  = 5'b00010,
		S_DIV    = 5'b00100,
		S_POINT  = 5'b01000,
		S_REPORT = 5'b10000
	} state_t;

	typedef struct packed {
		logic accept;
		logic setup;
		logic div_step;
		logic point_load;
		logic report_load;
	} cmd_t;

	typedef struct packed {
		logic need_div;
	} dp_stat_t;

endpackage

### hdl/ifpr_regs.sv
// Configuration registers of the root finder behind the APB-style port.
// Depends on ifpr_pkg.
module ifpr_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	output logic [ifpr_pkg::IW-1:0] max_iter,
	output logic [ifpr_pkg::TW-1:0] tol
);
	import ifpr_pkg::*;

	logic [IW-1:0] max_iter_q;
	logic [TW-1:0] tol_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Register write on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= IW'(100);
			tol_q      <= TW'(65);
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MAX_ITER:  max_iter_q <= pwdata[IW-1:0];
				REG_TOLERANCE: tol_q      <= pwdata[TW-1:0];
				default:       max_iter_q <= max_iter_q;
			endcase
		end
	end

	// Read data selection.
	always_comb begin
		unique case (paddr[2])
			REG_MAX_ITER:  prdata = {{(32-IW){1'b0}}, max_iter_q};
			REG_TOLERANCE: prdata = {{(32-TW){1'b0}}, tol_q};
			default:       prdata = '0;
		endcase
	end

	assign max_iter = max_iter_q;
	assign tol      = tol_q;

endmodule

### hdl/ifpr_ctrl.sv
// Controller of the root finder: sequences accept, divider setup, the
// division steps, point update and report. Depends on ifpr_pkg.
module ifpr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  ifpr_pkg::dp_stat_t stat,
	output ifpr_pkg::cmd_t     cmd
);
	import ifpr_pkg::*;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	// Commands to the datapath.
	always_comb begin
		cmd             = '0;
		cmd.accept      = in_valid && (state_q == S_IDLE);
		cmd.setup       = (state_q == S_SETUP);
		cmd.div_step    = (state_q == S_DIV);
		cmd.point_load  = (state_q == S_POINT);
		cmd.report_load = (state_q == S_REPORT) && slot_free;
	end

	// State sequencing and the division step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= stat.need_div ? S_SETUP : S_REPORT;
				end
				S_SETUP: begin
					cnt_q   <= CNT_W'(VW - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0) state_q <= S_POINT;
					else cnt_q <= cnt_q - 1'b1;
				end
				S_POINT:  state_q <= S_REPORT;
				S_REPORT: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Output valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.report_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/ifpr_dp.sv
// Datapath of the root finder: bracket state, restoring divider, point
// update and result register. Depends on ifpr_pkg.
module ifpr_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ifpr_pkg::cmd_t          cmd,
	output ifpr_pkg::dp_stat_t      stat,
	input  logic [ifpr_pkg::IW-1:0] max_iter,
	input  logic [ifpr_pkg::TW-1:0] tol,
	input  logic                    req_type,
	input  logic signed [31:0]      bound_a,
	input  logic signed [31:0]      bound_b,
	input  logic signed [31:0]      f_at_a,
	input  logic signed [31:0]      f_at_b,
	input  logic signed [31:0]      f_value,
	output logic signed [31:0]      point,
	output logic [2:0]              status,
	output logic [ifpr_pkg::IW-1:0] iterations
);
	import ifpr_pkg::*;

	localparam logic [VW-1:0] SIGN = {1'b1, {(VW-1){1'b0}}};

	logic [VW-1:0]   low_q, high_q, flow_q, fhigh_q, cur_q;
	logic [1:0]      last_q;
	logic [IW-1:0]   iter_q;
	logic            active_q;
	logic            dbl_w_q, dbl_v_q;
	rep_mode_t       mode_q;
	logic [VW:0]     v_q;
	logic [VW+1:0]   s_q, rem_q;
	logic [VW-1:0]   m_q, quo_q;
	logic            zero_q;
	logic [VW-1:0]   point_q;
	status_t         status_q;
	logic [IW-1:0]   iter_out_q;

	logic [VW-1:0]   o_low, o_high, o_flow, o_fhigh;
	logic            bad;
	logic [VW-1:0]   kl, kh, width, vneg, q;
	logic            up;
	logic [VW:0]     w_ext, v_ext;
	logic [VW+1:0]   s_sum;
	logic [VW+3:0]   t, s1, s2;
	logic [1:0]      d;
	logic [VW+3:0]   t_next;

	// Start ordering by function value and bracket check.
	always_comb begin
		if ((f_at_a ^ SIGN) > (f_at_b ^ SIGN)) begin
			o_low = bound_b; o_flow = f_at_b; o_high = bound_a; o_fhigh = f_at_a;
		end else begin
			o_low = bound_a; o_flow = f_at_a; o_high = bound_b; o_fhigh = f_at_b;
		end
		bad = (!o_flow[VW-1] && (o_flow != '0)) || o_fhigh[VW-1];
	end

	assign stat.need_div = req_type ? active_q : !bad;

	// Bracket width and direction.
	always_comb begin
		kl    = low_q ^ SIGN;
		kh    = high_q ^ SIGN;
		up    = (kh >= kl);
		width = up ? (kh - kl) : (kl - kh);
	end

	// Weights with the Illinois doubling.
	always_comb begin
		vneg  = '0 - flow_q;
		w_ext = dbl_w_q ? {fhigh_q, 1'b0} : {1'b0, fhigh_q};
		v_ext = dbl_v_q ? {vneg, 1'b0} : {1'b0, vneg};
		s_sum = {1'b0, w_ext} + {1'b0, v_ext};
	end

	// One radix-2 division step; the remainder may exceed the divisor twice.
	always_comb begin
		t  = {1'b0, rem_q, 1'b0} + (m_q[VW-1] ? {3'b0, v_q} : '0);
		s1 = {2'b0, s_q};
		s2 = {1'b0, s_q, 1'b0};
		priority if (t >= s2) begin
			d = 2'd2; t_next = t - s2;
		end else if (t >= s1) begin
			d = 2'd1; t_next = t - s1;
		end else begin
			d = 2'd0; t_next = t;
		end
	end

	assign q = zero_q ? (width >> 1) : quo_q;

	// Search state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= '0;
			high_q   <= '0;
			flow_q   <= '0;
			fhigh_q  <= '0;
			cur_q    <= '0;
			last_q   <= KEEP_NONE;
			iter_q   <= '0;
			active_q <= 1'b0;
			dbl_w_q  <= 1'b0;
			dbl_v_q  <= 1'b0;
			mode_q   <= MODE_NORMAL;
		end else if (cmd.accept) begin
			if (!req_type) begin
				low_q   <= o_low;
				high_q  <= o_high;
				flow_q  <= o_flow;
				fhigh_q <= o_fhigh;
				iter_q  <= '0;
				last_q  <= KEEP_NONE;
				dbl_w_q <= 1'b0;
				dbl_v_q <= 1'b0;
				if (bad) begin
					active_q <= 1'b0;
					cur_q    <= '0;
					mode_q   <= MODE_BAD;
				end else begin
					active_q <= 1'b1;
					mode_q   <= MODE_NORMAL;
				end
			end else if (!active_q) begin
				mode_q <= MODE_IDLE;
			end else begin
				mode_q <= MODE_NORMAL;
				iter_q <= iter_q + 1'b1;
				if (f_value[VW-1]) begin
					low_q   <= cur_q;
					flow_q  <= f_value;
					dbl_w_q <= (last_q == KEEP_LOW);
					dbl_v_q <= 1'b0;
					last_q  <= KEEP_LOW;
				end else begin
					high_q  <= cur_q;
					fhigh_q <= f_value;
					dbl_w_q <= 1'b0;
					dbl_v_q <= (last_q == KEEP_HIGH);
					last_q  <= KEEP_HIGH;
				end
			end
		end else if (cmd.point_load) begin
			cur_q <= up ? (low_q + q) : (low_q - q);
		end else if (cmd.report_load && (mode_q == MODE_NORMAL)) begin
			if ((iter_q >= max_iter) || (width < {1'b0, tol})) active_q <= 1'b0;
		end
	end

	// Divider registers.
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			v_q    <= v_ext;
			s_q    <= s_sum;
			m_q    <= width;
			rem_q  <= '0;
			quo_q  <= '0;
			zero_q <= (s_sum == '0);
		end else if (cmd.div_step) begin
			rem_q <= t_next[VW+1:0];
			quo_q <= {quo_q[VW-2:0], 1'b0} + {{(VW-2){1'b0}}, d};
			m_q   <= {m_q[VW-2:0], 1'b0};
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.report_load) begin
			unique case (mode_q)
				MODE_BAD: begin
					point_q <= '0; status_q <= STAT_BAD; iter_out_q <= '0;
				end
				MODE_IDLE: begin
					point_q <= '0; status_q <= STAT_NO_SEARCH; iter_out_q <= '0;
				end
				default: begin
					point_q <= cur_q;
					priority if (iter_q >= max_iter) begin
						status_q <= STAT_LIMIT; iter_out_q <= iter_q;
					end else if (width < {1'b0, tol}) begin
						status_q <= STAT_CONVERGED; iter_out_q <= iter_q + 1'b1;
					end else begin
						status_q <= STAT_EVAL; iter_out_q <= iter_q;
					end
				end
			endcase
		end
	end

	assign point      = point_q;
	assign status     = status_q;
	assign iterations = iter_out_q;

endmodule

### hdl/illinois_false_position_root_finder.sv
// A start with a valid bracket or a value during a search passes through setup,
// the division steps, point update and report before its result is registered;
// other requests go straight to report. One request at a time, set by the 32-step
// shared divider; a new one is taken only back in idle, and report waits on a stall.
// Reset: asynchronous, active low; clears the search, config to 100 and 65.
// Top level of the root finder; depends on ifpr_pkg, ifpr_regs, ifpr_ctrl
// and ifpr_dp.
module illinois_false_position_root_finder (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    req_type,
	input  logic signed [31:0]      bound_a,
	input  logic signed [31:0]      bound_b,
	input  logic signed [31:0]      f_at_a,
	input  logic signed [31:0]      f_at_b,
	input  logic signed [31:0]      f_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [31:0]      point,
	output logic [2:0]              status,
	output logic [9:0]              iterations
);
	import ifpr_pkg::*;

	logic [IW-1:0] max_iter;
	logic [TW-1:0] tol;
	cmd_t          cmd;
	dp_stat_t      stat;

	// Configuration registers.
	ifpr_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .max_iter, .tol
	);

	// Sequencer.
	ifpr_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd
	);

	// Arithmetic and state.
	ifpr_dp u_dp (
		.clk, .arst_n, .cmd, .stat, .max_iter, .tol,
		.req_type, .bound_a, .bound_b, .f_at_a, .f_at_b, .f_value,
		.point, .status, .iterations
	);

endmodule

### hdl/ifpr_checker.sv
// Port-level checker of the root finder, bound to the top level.
// Depends on ifpr_pkg and the assertion macros in the defines header.
`include "illinois_false_position_root_finder_defines.svh"

module ifpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] point,
	input logic [2:0]  status,
	input logic [9:0]  iterations
);
	import ifpr_pkg::*;

	// A stalled result holds.
	`IFPR_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(point), "stalled result changed")

	// A request is worked on alone.
	`IFPR_ASSERT(a_one_at_a_time, clk, arst_n, in_valid && in_ready |=> !in_ready, "request taken while busy")

	// Status codes stay in range.
	`IFPR_ASSERT(a_status_range, clk, arst_n, out_valid |-> status <= STAT_NO_SEARCH, "bad status code")

	// Rejections carry no point and no count.
	`IFPR_ASSERT(a_reject_zero, clk, arst_n, out_valid && (status == STAT_BAD || status == STAT_NO_SEARCH) |-> point == '0 && iterations == '0, "rejection with payload")

	// The register port never waits.
	`IFPR_ASSERT_ALWAYS(a_pready, clk, arst_n, pready, "pready low")

endmodule

bind illinois_false_position_root_finder ifpr_checker u_ifpr_checker (
	.clk, .arst_n, .pready, .in_valid, .in_ready, .out_valid, .out_ready,
	.point, .status, .iterations
);
